// ----- src/sha256_crypt_key_derivation_unit_assert.svh -----
// Assertion macros for the SHA-256 crypt key derivation unit.
// Used by modules that include this header; expects clk and rst_n in scope.
`ifndef SHA256_CRYPT_KEY_DERIVATION_UNIT_ASSERT_SVH
`define SHA256_CRYPT_KEY_DERIVATION_UNIT_ASSERT_SVH

// checked only while out of reset
`define SCKD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define SCKD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/sckd_pkg.sv -----
// Shared types and constants for the SHA-256 crypt key derivation unit.
// No dependencies; imported by the compression core and the top level.
package sckd_pkg;

    localparam int MAX_KEY_BYTES  = 125;
    localparam int MAX_SALT_BYTES = 16;
    localparam int KEY_CNT_W      = $clog2(MAX_KEY_BYTES + 1);

    localparam logic [29:0] ROUNDS_LOW   = 30'd1000;
    localparam logic [29:0] ROUNDS_HIGH  = 30'd999999999;
    localparam logic [29:0] ROUNDS_RESET = 30'd5000;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_SALT_FIRST  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SALT_SECOND = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SALT_LENGTH = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROUND_COUNT = 2'd3;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       byte_present;
        logic       key_last;
    } sckd_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sckd_out_t;

    typedef struct packed {
        logic init;   // load the initial chaining value
        logic start;  // compress the current block
    } sckd_core_ctl_t;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ----- src/sckd_sha_core.sv -----
// SHA-256 compression core: one round per clock, 64 rounds plus a chain update.
// Depends on sckd_pkg (round constants, initial value, control struct).
module sckd_sha_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sckd_pkg::sckd_core_ctl_t ctl,
    input  logic [511:0]           block,
    output logic                   busy,
    output logic [255:0]           chain
);
    import sckd_pkg::*;

    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic        busy_reg;
    logic [6:0]  cnt_reg;

    logic [31:0] t1, t2, nw, sig0, sig1;

    always_comb
    begin
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + SHA_K[cnt_reg[5:0]] + w_reg[0];
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        sig0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        sig1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        nw = w_reg[0] + sig0 + w_reg[9] + sig1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg[6])
                busy_reg <= 1'b0;
            cnt_reg <= cnt_reg + 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.init)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= SHA_IV[i];
        end
        else if (ctl.start)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
            for (int i = 0; i < 16; i++)
                w_reg[i] <= block[511 - 32 * i -: 32];
        end
        else if (busy_reg)
        begin
            if (cnt_reg[6])
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
            end
            else
            begin
                v_reg[0] <= t1 + t2;
                v_reg[1] <= v_reg[0];
                v_reg[2] <= v_reg[1];
                v_reg[3] <= v_reg[2];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[5] <= v_reg[4];
                v_reg[6] <= v_reg[5];
                v_reg[7] <= v_reg[6];
                for (int i = 0; i < 15; i++)
                    w_reg[i] <= w_reg[i + 1];
                w_reg[15] <= nw;
            end
        end
    end

    assign busy  = busy_reg;
    assign chain = {h_reg[0], h_reg[1], h_reg[2], h_reg[3],
                    h_reg[4], h_reg[5], h_reg[6], h_reg[7]};

endmodule

// ----- src/sha256_crypt_key_derivation_unit.sv -----
// SHA-256 crypt key derivation, top level: key store, byte sequencer, result output.
// Depends on sckd_pkg, sckd_sha_core and the assertion macro header.
//
// Password bytes arrive one word per cycle while in_ready is high and are
// stored (bytes past 125 are dropped). A word without key_last is only stored.
// The word marked key_last starts a derivation with the current salt and round
// count. The input then stays not ready until all eight result words are taken.
// All hashing runs through one SHA-256 round unit. The sequencer feeds the
// message one byte per cycle while the core is not busy and the block is not
// full; each full 64-byte block then stalls the feed for byte landing, start,
// 64 rounds and the chain update. A derivation therefore takes rounds + 4
// hashes. The salt and round count registers must only be written while
// the block is idle.
module sha256_crypt_key_derivation_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  sckd_pkg::sckd_in_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output sckd_pkg::sckd_out_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sckd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [63:0]                         cfg_data
);
    import sckd_pkg::*;
    `include "sha256_crypt_key_derivation_unit_assert.svh"

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEG    = 3'd1;
    localparam logic [2:0] ST_PAD80  = 3'd2;
    localparam logic [2:0] ST_PADZ   = 3'd3;
    localparam logic [2:0] ST_PADLEN = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    localparam logic [2:0] H_ALT = 3'd0;
    localparam logic [2:0] H_RUN = 3'd1;
    localparam logic [2:0] H_P   = 3'd2;
    localparam logic [2:0] H_S   = 3'd3;
    localparam logic [2:0] H_RND = 3'd4;

    localparam logic [2:0] SRC_KEY  = 3'd0;
    localparam logic [2:0] SRC_SALT = 3'd1;
    localparam logic [2:0] SRC_SDG  = 3'd2;  // alternate digest, later S digest
    localparam logic [2:0] SRC_PDG  = 3'd3;
    localparam logic [2:0] SRC_RUN  = 3'd4;

    // configuration
    logic [63:0] salt_first_reg, salt_second_reg;
    logic [4:0]  salt_len_reg;
    logic [29:0] rcount_reg;

    // key store
    logic [7:0]           key_mem [MAX_KEY_BYTES];
    logic [7:0]           key_q_reg;
    logic [KEY_CNT_W-1:0] kcount_reg, kcount_next;

    // sequencer
    logic [2:0]  state_reg, state_next;
    logic [2:0]  hash_reg, hash_next;
    logic [2:0]  seg_reg, seg_next;
    logic [8:0]  rep_reg, rep_next;
    logic [6:0]  idx_reg, idx_next;
    logic [2:0]  lcnt_reg, lcnt_next;
    logic [6:0]  slot_reg, slot_next;
    logic [15:0] mlen_reg, mlen_next;
    logic [29:0] round_reg, round_next;
    logic [29:0] lim_reg, lim_next;
    logic [1:0]  mod3_reg, mod3_next;
    logic [2:0]  mod7_reg, mod7_next;
    logic [2:0]  oidx_reg, oidx_next;

    // byte landing stage
    logic       pend_valid_reg;
    logic [5:0] pend_pos_reg;
    logic       pend_key_reg;
    logic [7:0] pbyte_reg;

    logic [511:0] block_reg;
    logic [255:0] run_reg, p_reg, s_reg;
    logic [255:0] run_next, p_next, s_next;

    logic         core_busy;
    logic [255:0] core_chain;
    sckd_core_ctl_t core_ctl;

    logic        in_fire, out_fire;
    logic        can_issue, issue, issue_key, count_len;
    logic [7:0]  issue_byte;
    logic        desc_pad, desc_loop;
    logic [2:0]  desc_src;
    logic [6:0]  desc_len;
    logic [6:0]  klen, slen;
    logic [4:0]  slen_clamp;
    logic [7:0]  src_byte;
    logic [127:0] salt_all;
    logic [63:0] len_bits;
    logic        odd;
    logic [29:0] rclamp;

    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign cfg_ready = 1'b1;

    assign slen_clamp = (salt_len_reg > 5'(MAX_SALT_BYTES)) ? 5'(MAX_SALT_BYTES) : salt_len_reg;
    assign klen       = 7'(kcount_reg);
    assign slen       = {2'b00, slen_clamp};
    assign salt_all   = {salt_first_reg, salt_second_reg};
    assign len_bits   = {45'd0, mlen_reg, 3'b000};
    assign odd        = round_reg[0];
    assign rclamp     = (rcount_reg < ROUNDS_LOW) ? ROUNDS_LOW :
                        (rcount_reg > ROUNDS_HIGH) ? ROUNDS_HIGH : rcount_reg;
    assign can_issue  = !slot_reg[6] && !core_busy;

    assign out_data.digest_word = run_reg[255 - 32 * oidx_reg -: 32];
    assign out_data.word_index  = oidx_reg;
    assign out_data.last_word   = (oidx_reg == 3'd7);

    // segment of the current hash message
    always_comb
    begin
        desc_pad  = 1'b0;
        desc_loop = 1'b0;
        desc_src  = SRC_KEY;
        desc_len  = klen;
        case (hash_reg)
            H_ALT:
            begin
                case (seg_reg)
                    3'd0: desc_src = SRC_KEY;
                    3'd1: begin desc_src = SRC_SALT; desc_len = slen; end
                    3'd2: desc_src = SRC_KEY;
                    default: desc_pad = 1'b1;
                endcase
            end
            H_RUN:
            begin
                case (seg_reg)
                    3'd0: desc_src = SRC_KEY;
                    3'd1: begin desc_src = SRC_SALT; desc_len = slen; end
                    3'd2: desc_src = SRC_SDG;
                    3'd3:
                    begin
                        // walk the bits of the key length, low bit first
                        desc_loop = 1'b1;
                        if (rep_reg == '0)
                            desc_pad = 1'b1;
                        else if (rep_reg[0])
                        begin
                            desc_src = SRC_SDG;
                            desc_len = 7'd32;
                        end
                    end
                    default: desc_pad = 1'b1;
                endcase
            end
            H_P:
            begin
                desc_loop = 1'b1;
                desc_pad  = (rep_reg == '0);
            end
            H_S:
            begin
                desc_loop = 1'b1;
                desc_pad  = (rep_reg == '0);
                desc_src  = SRC_SALT;
                desc_len  = slen;
            end
            H_RND:
            begin
                case (seg_reg)
                    3'd0:
                    begin
                        desc_src = odd ? SRC_PDG : SRC_RUN;
                        desc_len = odd ? klen : 7'd32;
                    end
                    3'd1:
                    begin
                        desc_src = SRC_SDG;
                        desc_len = (mod3_reg != 2'd0) ? slen : 7'd0;
                    end
                    3'd2:
                    begin
                        desc_src = SRC_PDG;
                        desc_len = (mod7_reg != 3'd0) ? klen : 7'd0;
                    end
                    3'd3:
                    begin
                        desc_src = odd ? SRC_RUN : SRC_PDG;
                        desc_len = odd ? 7'd32 : klen;
                    end
                    default: desc_pad = 1'b1;
                endcase
            end
            default: desc_pad = 1'b1;
        endcase
    end

    always_comb
    begin
        case (desc_src)
            SRC_SALT: src_byte = salt_all[127 - 8 * idx_reg[3:0] -: 8];
            SRC_SDG:  src_byte = s_reg[255 - 8 * idx_reg[4:0] -: 8];
            SRC_PDG:  src_byte = p_reg[255 - 8 * idx_reg[4:0] -: 8];
            SRC_RUN:  src_byte = run_reg[255 - 8 * idx_reg[4:0] -: 8];
            default:  src_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        hash_next   = hash_reg;
        seg_next    = seg_reg;
        rep_next    = rep_reg;
        idx_next    = idx_reg;
        lcnt_next   = lcnt_reg;
        slot_next   = slot_reg;
        mlen_next   = mlen_reg;
        round_next  = round_reg;
        lim_next    = lim_reg;
        mod3_next   = mod3_reg;
        mod7_next   = mod7_reg;
        oidx_next   = oidx_reg;
        kcount_next = kcount_reg;
        run_next    = run_reg;
        p_next      = p_reg;
        s_next      = s_reg;
        issue       = 1'b0;
        issue_key   = 1'b0;
        issue_byte  = 8'h00;
        count_len   = 1'b0;
        core_ctl.init  = 1'b0;
        core_ctl.start = slot_reg[6] && !pend_valid_reg && !core_busy;

        if (core_ctl.start)
            slot_next = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_data.byte_present && (kcount_reg < KEY_CNT_W'(MAX_KEY_BYTES)))
                        kcount_next = kcount_reg + 1'b1;
                    if (in_data.key_last)
                    begin
                        lim_next      = rclamp;
                        hash_next     = H_ALT;
                        state_next    = ST_SEG;
                        seg_next      = '0;
                        idx_next      = '0;
                        slot_next     = '0;
                        mlen_next     = '0;
                        core_ctl.init = 1'b1;
                    end
                end
            end
            ST_SEG:
            begin
                if (desc_pad)
                    state_next = ST_PAD80;
                else if (idx_reg == desc_len)
                begin
                    idx_next = '0;
                    if (!desc_loop)
                        seg_next = seg_reg + 3'd1;
                    else if (hash_reg == H_RUN)
                        rep_next = rep_reg >> 1;
                    else
                        rep_next = rep_reg - 9'd1;
                end
                else if (can_issue)
                begin
                    issue      = 1'b1;
                    issue_key  = (desc_src == SRC_KEY);
                    issue_byte = src_byte;
                    count_len  = 1'b1;
                    idx_next   = idx_reg + 7'd1;
                end
            end
            ST_PAD80:
            begin
                if (can_issue)
                begin
                    issue      = 1'b1;
                    issue_byte = 8'h80;
                    state_next = ST_PADZ;
                end
            end
            ST_PADZ:
            begin
                if (slot_reg == 7'd56)
                begin
                    state_next = ST_PADLEN;
                    lcnt_next  = '0;
                end
                else if (can_issue)
                    issue = 1'b1;
            end
            ST_PADLEN:
            begin
                if (can_issue)
                begin
                    issue      = 1'b1;
                    issue_byte = len_bits[63 - 8 * lcnt_reg -: 8];
                    lcnt_next  = lcnt_reg + 3'd1;
                    if (lcnt_reg == 3'd7)
                        state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // final block compressed: store digest, open next hash or output
                if (slot_reg == '0 && !core_busy && !pend_valid_reg)
                begin
                    state_next    = ST_SEG;
                    seg_next      = '0;
                    idx_next      = '0;
                    slot_next     = '0;
                    mlen_next     = '0;
                    core_ctl.init = 1'b1;
                    case (hash_reg)
                        H_ALT:
                        begin
                            s_next    = core_chain;
                            hash_next = H_RUN;
                            rep_next  = {2'b00, klen};
                        end
                        H_RUN:
                        begin
                            run_next  = core_chain;
                            hash_next = H_P;
                            rep_next  = {2'b00, klen};
                        end
                        H_P:
                        begin
                            p_next    = core_chain;
                            hash_next = H_S;
                            rep_next  = 9'd16 + {1'b0, run_reg[255:248]};
                        end
                        H_S:
                        begin
                            s_next     = core_chain;
                            hash_next  = H_RND;
                            round_next = '0;
                            mod3_next  = '0;
                            mod7_next  = '0;
                        end
                        default:
                        begin
                            run_next = core_chain;
                            if (round_reg + 30'd1 == lim_reg)
                            begin
                                state_next    = ST_OUT;
                                core_ctl.init = 1'b0;
                                oidx_next     = '0;
                                kcount_next   = '0;
                            end
                            else
                            begin
                                round_next = round_reg + 30'd1;
                                mod3_next  = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
                                mod7_next  = (mod7_reg == 3'd6) ? 3'd0 : mod7_reg + 3'd1;
                            end
                        end
                    endcase
                end
            end
            ST_OUT:
            begin
                if (out_fire)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (issue)
            slot_next = slot_reg + 7'd1;
        if (count_len)
            mlen_next = mlen_reg + 16'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            hash_reg        <= H_ALT;
            seg_reg         <= '0;
            rep_reg         <= '0;
            idx_reg         <= '0;
            lcnt_reg        <= '0;
            slot_reg        <= '0;
            mlen_reg        <= '0;
            round_reg       <= '0;
            lim_reg         <= ROUNDS_RESET;
            mod3_reg        <= '0;
            mod7_reg        <= '0;
            oidx_reg        <= '0;
            kcount_reg      <= '0;
            pend_valid_reg  <= 1'b0;
            salt_first_reg  <= '0;
            salt_second_reg <= '0;
            salt_len_reg    <= '0;
            rcount_reg      <= ROUNDS_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            hash_reg       <= hash_next;
            seg_reg        <= seg_next;
            rep_reg        <= rep_next;
            idx_reg        <= idx_next;
            lcnt_reg       <= lcnt_next;
            slot_reg       <= slot_next;
            mlen_reg       <= mlen_next;
            round_reg      <= round_next;
            lim_reg        <= lim_next;
            mod3_reg       <= mod3_next;
            mod7_reg       <= mod7_next;
            oidx_reg       <= oidx_next;
            kcount_reg     <= kcount_next;
            pend_valid_reg <= issue;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SALT_FIRST:  salt_first_reg  <= cfg_data;
                    REG_SALT_SECOND: salt_second_reg <= cfg_data;
                    REG_SALT_LENGTH: salt_len_reg    <= cfg_data[4:0];
                    REG_ROUND_COUNT: rcount_reg      <= cfg_data[29:0];
                    default: ;
                endcase
            end
        end
    end

    // payload: landing stage, message block, digests
    always_ff @(posedge clk)
    begin
        pend_pos_reg <= slot_reg[5:0];
        pend_key_reg <= issue_key;
        pbyte_reg    <= issue_byte;
        run_reg      <= run_next;
        p_reg        <= p_next;
        s_reg        <= s_next;
        if (pend_valid_reg)
            block_reg[511 - 8 * pend_pos_reg -: 8] <= pend_key_reg ? key_q_reg : pbyte_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && in_data.byte_present && (kcount_reg < KEY_CNT_W'(MAX_KEY_BYTES)))
            key_mem[kcount_reg] <= in_data.key_byte;
        if (idx_reg < 7'(MAX_KEY_BYTES))
            key_q_reg <= key_mem[idx_reg];
    end

    sckd_sha_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (core_ctl),
        .block (block_reg),
        .busy  (core_busy),
        .chain (core_chain)
    );

    `SCKD_ASSERT(a_start_full, core_ctl.start |-> (slot_reg == 7'd64 && !pend_valid_reg), "compress started on a partial block")
    `SCKD_ASSERT(a_start_busy, core_ctl.start |=> core_busy, "core did not go busy after start")
    `SCKD_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(oidx_reg)), "result word dropped while stalled")
    `SCKD_ASSERT(a_kcount_cap, kcount_reg <= KEY_CNT_W'(MAX_KEY_BYTES), "key count past store depth")

endmodule
